### hw/rtl/variable_length_history_ring_defines.svh
// assertion helpers for the history ring, clocked on aclk with aresetn
`ifndef VARIABLE_LENGTH_HISTORY_RING_DEFINES_SVH
`define VARIABLE_LENGTH_HISTORY_RING_DEFINES_SVH

// property must hold at every edge out of reset
`define VLHR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
    else $error(msg);

// condition must never be seen out of reset
`define VLHR_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
    else $error(msg);

`endif

### hw/rtl/vlhr_pkg.sv
`default_nettype none
package vlhr_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  record_length;
        logic [7:0]  data_byte;
        logic [10:0] record_index;
        logic [7:0]  byte_offset;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  length_out;
        logic [7:0]  byte_out;
        logic [11:0] record_count;
        logic [12:0] bytes_used;
    } result_t;

endpackage
`default_nettype wire

### hw/rtl/variable_length_history_ring.sv
// channel   dir   handshake            payload
// s_        in    s_tvalid/s_tready    tdata: length, byte, index, offset; tuser: command
// m_        out   m_tvalid/m_tready    tdata: length, byte, count, used; tuser: found
//
// beats are processed one at a time: a new beat is accepted only after the engine has
// handed its result to the output register. a start with a length first evicts the oldest
// records until the new one fits; a read hit walks the length bytes from the head to the
// record (one walk hop per cycle), then fetches the byte if the offset lies inside it.
// synchronous active-low reset clears the head and tail pointers and counts; no memory sweep.
// a result parked in the output register does not block the next accept.
`default_nettype none
`include "variable_length_history_ring_defines.svh"
module variable_length_history_ring #(
    parameter int RING_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // record_length[7:0], data_byte[15:8], record_index[26:16], byte_offset[34:27]
    input  wire logic [39:0] s_tdata,
    // command[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // length_out[7:0], byte_out[15:8], record_count[27:16], bytes_used[40:28]
    output logic [47:0]      m_tdata,
    // found[0]
    output logic [0:0]       m_tuser
);
    import vlhr_pkg::*;

    localparam int AW = $clog2(RING_BYTES);

    in_item_t      item;
    result_t       eng_result;
    logic          eng_res_valid;
    logic          eng_res_ready;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg;

    always_comb begin
        item.command       = s_tuser;
        item.record_length = s_tdata[7:0];
        item.data_byte     = s_tdata[15:8];
        item.record_index  = s_tdata[26:16];
        item.byte_offset   = s_tdata[34:27];
    end

    vlhr_engine #(
        .RING_BYTES (RING_BYTES)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item        (item),
        .res_valid   (eng_res_valid),
        .res_ready   (eng_res_ready),
        .result      (eng_result),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    vlhr_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register frees the engine once its result is taken
    assign eng_res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (eng_res_valid && eng_res_ready) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_res_valid && eng_res_ready) begin
            out_reg <= eng_result;
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.found;
    assign m_tdata  = {7'd0, out_reg.bytes_used, out_reg.record_count,
                       out_reg.byte_out, out_reg.length_out};

    `VLHR_NEVER(a_busy_no_accept, s_tready && eng_res_valid, "accept while result pending")
    `VLHR_ASSERT(a_load_from_engine, $rose(m_tvalid) |-> $past(eng_res_valid), "beat w/o result")
    `VLHR_ASSERT(a_found_has_length, m_tvalid && m_tuser[0] |-> |m_tdata[7:0], "empty record found")
    `VLHR_NEVER(a_miss_is_zero, m_tvalid && !m_tuser[0] && |m_tdata[15:0], "miss data nonzero")

endmodule
`default_nettype wire

### hw/rtl/vlhr_ram.sv
`default_nettype none
module vlhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/vlhr_engine.sv
`default_nettype none
module vlhr_engine #(
    parameter int RING_BYTES = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire vlhr_pkg::in_item_t            item,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output vlhr_pkg::result_t                  result,
    output logic                               ram_wr_en,
    output logic [$clog2(RING_BYTES)-1:0]      ram_wr_addr,
    output logic [7:0]                         ram_wr_data,
    output logic                               ram_rd_en,
    output logic [$clog2(RING_BYTES)-1:0]      ram_rd_addr,
    input  wire logic [7:0]                    ram_rd_data
);
    import vlhr_pkg::*;

    localparam int AW = $clog2(RING_BYTES);
    localparam int UW = $clog2(RING_BYTES + 1);
    localparam int RW = $clog2(RING_BYTES / 2 + 1);
    localparam logic [AW:0] RING_SIZE_P = (AW + 1)'(RING_BYTES);
    localparam logic [UW:0] RING_SIZE_U = (UW + 1)'(RING_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EVICT_CHK,
        ST_EVICT_UPD,
        ST_WALK,
        ST_BYTE,
        ST_RESULT
    } state_t;

    state_t        state_reg, state_next;
    in_item_t      item_reg, item_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [UW-1:0] used_reg, used_next;
    logic [RW-1:0] rec_reg, rec_next;
    logic [7:0]    fill_rem_reg, fill_rem_next;
    logic [7:0]    fill_len_reg, fill_len_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] walk_ptr_reg, walk_ptr_next;
    logic [10:0]   walk_cnt_reg, walk_cnt_next;
    logic          found_reg, found_next;
    logic [7:0]    len_out_reg, len_out_next;
    logic [7:0]    byte_out_reg, byte_out_next;

    logic [8:0]    need;
    logic [8:0]    rd_span;
    logic [8:0]    fill_span;
    logic [8:0]    off_span;

    // modular add on the ring, span never exceeds the ring size
    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] p, logic [8:0] span);
        logic [AW:0] s;
        s = {1'b0, p} + (AW + 1)'(span);
        if (s >= RING_SIZE_P) begin
            s = s - RING_SIZE_P;
        end
        return s[AW-1:0];
    endfunction

    assign need      = {1'b0, item_reg.record_length} + 9'd1;
    assign rd_span   = {1'b0, ram_rd_data} + 9'd1;
    assign fill_span = {1'b0, fill_len_reg} + 9'd1;
    assign off_span  = {1'b0, item_reg.byte_offset} + 9'd1;

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_RESULT);

    always_comb begin
        result.found        = found_reg;
        result.length_out   = len_out_reg;
        result.byte_out     = byte_out_reg;
        result.record_count = 12'(rec_reg);
        result.bytes_used   = 13'(used_reg);
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        used_next     = used_reg;
        rec_next      = rec_reg;
        fill_rem_next = fill_rem_reg;
        fill_len_next = fill_len_reg;
        wr_ptr_next   = wr_ptr_reg;
        walk_ptr_next = walk_ptr_reg;
        walk_cnt_next = walk_cnt_reg;
        found_next    = found_reg;
        len_out_next  = len_out_reg;
        byte_out_next = byte_out_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = wr_ptr_reg;
        ram_wr_data   = item_reg.data_byte;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = head_reg;

        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_next  = item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                found_next    = 1'b0;
                len_out_next  = 8'd0;
                byte_out_next = 8'd0;
                state_next    = ST_RESULT;
                case (item_reg.command)
                    CMD_START: begin
                        if (item_reg.record_length != 8'd0) begin
                            state_next = ST_EVICT_CHK;
                        end
                    end
                    CMD_BYTE: begin
                        if (fill_rem_reg != 8'd0) begin
                            ram_wr_en     = 1'b1;
                            wr_ptr_next   = ring_add(wr_ptr_reg, 9'd1);
                            fill_rem_next = fill_rem_reg - 8'd1;
                            if (fill_rem_reg == 8'd1) begin
                                tail_next = ring_add(tail_reg, fill_span);
                                used_next = used_reg + UW'(fill_span);
                                rec_next  = rec_reg + RW'(1);
                            end
                        end
                    end
                    CMD_READ: begin
                        if ((RW + 11)'(item_reg.record_index) < (RW + 11)'(rec_reg)) begin
                            found_next    = 1'b1;
                            walk_ptr_next = head_reg;
                            walk_cnt_next = item_reg.record_index;
                            ram_rd_en     = 1'b1;
                            ram_rd_addr   = head_reg;
                            state_next    = ST_WALK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_EVICT_CHK: begin
                if ((({1'b0, used_reg} + (UW + 1)'(need)) > RING_SIZE_U)
                        && (rec_reg != RW'(0))) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = head_reg;
                    state_next  = ST_EVICT_UPD;
                end else begin
                    // length byte at the tail opens the record
                    ram_wr_en     = 1'b1;
                    ram_wr_addr   = tail_reg;
                    ram_wr_data   = item_reg.record_length;
                    wr_ptr_next   = ring_add(tail_reg, 9'd1);
                    fill_rem_next = item_reg.record_length;
                    fill_len_next = item_reg.record_length;
                    state_next    = ST_RESULT;
                end
            end
            ST_EVICT_UPD: begin
                head_next  = ring_add(head_reg, rd_span);
                used_next  = used_reg - UW'(rd_span);
                rec_next   = rec_reg - RW'(1);
                state_next = ST_EVICT_CHK;
            end
            ST_WALK: begin
                if (walk_cnt_reg == 11'd0) begin
                    len_out_next = ram_rd_data;
                    if (item_reg.byte_offset < ram_rd_data) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ring_add(walk_ptr_reg, off_span);
                        state_next  = ST_BYTE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    // hop to the next length byte and fetch it right away
                    walk_ptr_next = ring_add(walk_ptr_reg, rd_span);
                    walk_cnt_next = walk_cnt_reg - 11'd1;
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = walk_ptr_next;
                end
            end
            ST_BYTE: begin
                byte_out_next = ram_rd_data;
                state_next    = ST_RESULT;
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        fill_len_reg <= fill_len_next;
        wr_ptr_reg   <= wr_ptr_next;
        walk_ptr_reg <= walk_ptr_next;
        walk_cnt_reg <= walk_cnt_next;
        found_reg    <= found_next;
        len_out_reg  <= len_out_next;
        byte_out_reg <= byte_out_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            used_reg     <= '0;
            rec_reg      <= '0;
            fill_rem_reg <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            used_reg     <= used_next;
            rec_reg      <= rec_next;
            fill_rem_reg <= fill_rem_next;
        end
    end

endmodule
`default_nettype wire
